// ===== hdl/cdd_pkg.sv =====
// Shared types, constants and calendar helpers for the countdown difference block.
package cdd_pkg;

  typedef struct packed {
    logic [5:0] deadline_year;
    logic [3:0] deadline_month;
    logic [4:0] deadline_day;
    logic [4:0] deadline_hour;
    logic [5:0] deadline_minute;
    logic [5:0] deadline_second;
    logic [5:0] now_year;
    logic [3:0] now_month;
    logic [4:0] now_day;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
  } cdd_in_t;

  typedef enum logic [1:0] {
    MODE_YEARS  = 2'd0,
    MODE_MONTHS = 2'd1,
    MODE_DAYS   = 2'd2,
    MODE_HMS    = 2'd3
  } cdd_mode_t;

  typedef struct packed {
    logic [5:0] remaining_years;
    logic [3:0] remaining_months;
    logic [4:0] remaining_days;
    logic [4:0] remaining_hours;
    logic [5:0] remaining_minutes;
    logic [5:0] remaining_seconds;
    cdd_mode_t  display_mode;
    logic       expired;
  } cdd_out_t;

  // Working width for a unit difference including one borrow.
  localparam int unsigned DiffW = 8;
  typedef logic signed [DiffW-1:0] cdd_diff_t;

  localparam cdd_diff_t SecBorrow   = 8'sd60;
  localparam cdd_diff_t MinBorrow   = 8'sd60;
  localparam cdd_diff_t HourBorrow  = 8'sd24;
  localparam cdd_diff_t MonthBorrow = 8'sd12;

  localparam cdd_diff_t SecMax   = 8'sd59;
  localparam cdd_diff_t MinMax   = 8'sd59;
  localparam cdd_diff_t HourMax  = 8'sd23;
  localparam cdd_diff_t DayMax   = 8'sd30;
  localparam cdd_diff_t MonthMax = 8'sd11;
  localparam cdd_diff_t YearMax  = 8'sd63;

  // Years run 2020..2083, so no century year is in range: leap iff field is a multiple of 4.
  function automatic logic leap_year(logic [5:0] yfield);
    leap_year = (yfield[1:0] == 2'd0);
  endfunction

  // Length of the month before month m (1 = January); out-of-range months wrap modulo 12.
  function automatic logic [4:0] prev_month_len(logic [3:0] m, logic [5:0] yfield);
    logic [4:0] len;
    len = 5'd31;
    case (m)
      4'd0:  len = 5'd30;
      4'd1:  len = 5'd31;
      4'd2:  len = 5'd31;
      4'd3:  len = leap_year(yfield) ? 5'd29 : 5'd28;
      4'd4:  len = 5'd31;
      4'd5:  len = 5'd30;
      4'd6:  len = 5'd31;
      4'd7:  len = 5'd30;
      4'd8:  len = 5'd31;
      4'd9:  len = 5'd31;
      4'd10: len = 5'd30;
      4'd11: len = 5'd31;
      4'd12: len = 5'd30;
      4'd13: len = 5'd31;
      4'd14: len = 5'd31;
      4'd15: len = leap_year(yfield) ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    prev_month_len = len;
  endfunction

endpackage

// ===== hdl/cdd_diff.sv =====
// Combinational subtract-and-borrow core: one date-time pair in, one countdown out.
module cdd_diff (
  input  cdd_pkg::cdd_in_t  in_item,
  output cdd_pkg::cdd_out_t out_item
);

  logic [31:0] dl_key;
  logic [31:0] nw_key;
  logic        is_expired;

  assign dl_key = {in_item.deadline_year, in_item.deadline_month, in_item.deadline_day,
                   in_item.deadline_hour, in_item.deadline_minute, in_item.deadline_second};
  assign nw_key = {in_item.now_year, in_item.now_month, in_item.now_day,
                   in_item.now_hour, in_item.now_minute, in_item.now_second};
  assign is_expired = (dl_key < nw_key);

  always_comb begin
    cdd_pkg::cdd_diff_t us;
    cdd_pkg::cdd_diff_t um;
    cdd_pkg::cdd_diff_t uh;
    cdd_pkg::cdd_diff_t ud;
    cdd_pkg::cdd_diff_t umo;
    cdd_pkg::cdd_diff_t uy;
    cdd_pkg::cdd_diff_t day_borrow;

    us  = $signed({2'b00, in_item.deadline_second}) - $signed({2'b00, in_item.now_second});
    um  = $signed({2'b00, in_item.deadline_minute}) - $signed({2'b00, in_item.now_minute});
    uh  = $signed({3'b000, in_item.deadline_hour}) - $signed({3'b000, in_item.now_hour});
    ud  = $signed({3'b000, in_item.deadline_day}) - $signed({3'b000, in_item.now_day});
    umo = $signed({4'b0000, in_item.deadline_month}) - $signed({4'b0000, in_item.now_month});
    uy  = $signed({2'b00, in_item.deadline_year}) - $signed({2'b00, in_item.now_year});
    day_borrow = $signed({3'b000,
                 cdd_pkg::prev_month_len(in_item.deadline_month, in_item.deadline_year)});

    if (us < 0) begin
      us = us + cdd_pkg::SecBorrow;
      um = um - 8'sd1;
      if (us < 0) us = '0;
    end
    if (us > cdd_pkg::SecMax) us = cdd_pkg::SecMax;

    if (um < 0) begin
      um = um + cdd_pkg::MinBorrow;
      uh = uh - 8'sd1;
      if (um < 0) um = '0;
    end
    if (um > cdd_pkg::MinMax) um = cdd_pkg::MinMax;

    if (uh < 0) begin
      uh = uh + cdd_pkg::HourBorrow;
      ud = ud - 8'sd1;
      if (uh < 0) uh = '0;
    end
    if (uh > cdd_pkg::HourMax) uh = cdd_pkg::HourMax;

    if (ud < 0) begin
      ud = ud + day_borrow;
      umo = umo - 8'sd1;
      if (ud < 0) ud = '0;
    end
    if (ud > cdd_pkg::DayMax) ud = cdd_pkg::DayMax;

    if (umo < 0) begin
      umo = umo + cdd_pkg::MonthBorrow;
      uy = uy - 8'sd1;
      if (umo < 0) umo = '0;
    end
    if (umo > cdd_pkg::MonthMax) umo = cdd_pkg::MonthMax;

    if (uy < 0) uy = '0;
    if (uy > cdd_pkg::YearMax) uy = cdd_pkg::YearMax;

    if (is_expired) begin
      out_item = '0;
      out_item.display_mode = cdd_pkg::MODE_HMS;
      out_item.expired = 1'b1;
    end else begin
      out_item.remaining_years   = uy[5:0];
      out_item.remaining_months  = umo[3:0];
      out_item.remaining_days    = ud[4:0];
      out_item.remaining_hours   = uh[4:0];
      out_item.remaining_minutes = um[5:0];
      out_item.remaining_seconds = us[5:0];
      if (uy > 0)       out_item.display_mode = cdd_pkg::MODE_YEARS;
      else if (umo > 0) out_item.display_mode = cdd_pkg::MODE_MONTHS;
      else if (ud > 0)  out_item.display_mode = cdd_pkg::MODE_DAYS;
      else              out_item.display_mode = cdd_pkg::MODE_HMS;
      out_item.expired = 1'b0;
    end
  end

endmodule

// ===== hdl/calendar_countdown_difference.sv =====
// Top level: input register, countdown core and result register.
// Each accepted transaction passes through in_r, the core and out_r and is then
// on out_data with out_valid high (two register stages, one core between them).
// Throughput: one transaction per cycle; busy is never raised and results are
// never held off. Reset (synchronous, rst_n low) clears both valid flags only.
module calendar_countdown_difference (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cdd_pkg::cdd_in_t  in_data,
  output logic              out_valid,
  output cdd_pkg::cdd_out_t out_data
);

  cdd_pkg::cdd_in_t  in_r;
  logic              in_vld_r;
  cdd_pkg::cdd_out_t core_out;
  cdd_pkg::cdd_out_t out_r;
  logic              out_vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start & ~busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) in_r <= in_data;
    if (in_vld_r) out_r <= core_out;
  end

  cdd_diff u_diff (
    .in_item  (in_r),
    .out_item (core_out)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
